// ----- rtl/irck_pkg.sv -----
// ============================================================================
// irck_pkg
// shared types, constants and table functions for the rotate / color key block
// ============================================================================
package irck_pkg;

  // default sizes
  localparam int unsigned MAX_DIM_DEF   = 128;
  localparam int unsigned TRIG_FRAC_DEF = 14;

  // field widths
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned SRC_W      = 8;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // angle handling
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'd360;
  localparam int unsigned SINE_ENTRIES = 91;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'd0;

  // register reset values
  localparam logic [7:0]         WIDTH_RST  = 8'd128;
  localparam logic [7:0]         HEIGHT_RST = 8'd128;
  localparam logic [8:0]         ANGLE_RST  = 9'd0;
  localparam logic [COLOR_W-1:0] KEY_RST    = '0;

  // pi in Q31
  localparam longint unsigned PI_Q31 = 64'd6746518852;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_ANGLE  = 3'd2,
    REG_KEY    = 3'd3,
    REG_KEY_EN = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_COPY
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_WAIT
  } bk_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [COLOR_W-1:0] pixel_color;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   out_column;
    logic [POS_W-1:0]   out_row;
    logic [COLOR_W-1:0] out_color;
    logic [ALPHA_W-1:0] out_alpha;
    logic               source_in_range;
  } out_res_t;

  typedef struct packed {
    logic [7:0]         width;
    logic [7:0]         height;
    logic [8:0]         angle;
    logic [COLOR_W-1:0] key_color;
    logic               key_enable;
  } cfg_t;

  typedef struct packed {
    cmd_e               kind;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [SRC_W-1:0]   src_col;
    logic [SRC_W-1:0]   src_row;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // restoring long division, used only while building the sine table
  function automatic longint unsigned irck_udiv64(input longint unsigned num,
                                                  input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // sin(k degrees) rounded to frac fraction bits, taylor series in Q31
  function automatic logic [31:0] irck_sine_q(input int unsigned k, input int unsigned frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned v;
    longint unsigned den;
    x    = (longint'(k) * PI_Q31 + 64'd90) / 64'd180;
    x2   = (x * x) >> 31;
    term = x;
    pos  = x;
    neg  = 0;
    for (int unsigned n = 1; n < 20; n++) begin
      den  = longint'(2 * n) * longint'(2 * n + 1);
      term = irck_udiv64((term * x2) >> 31, den);
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    v = (pos > neg) ? pos - neg : 64'd0;
    return 32'((v + (64'd1 << (30 - frac))) >> (31 - frac));
  endfunction

endpackage

// ----- rtl/irck_ram.sv -----
// ============================================================================
// irck_ram
// generic simple dual-port ram, one write port, one registered read port
// ============================================================================
module irck_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/irck_front.sv -----
// ============================================================================
// irck_front
// accepts requests, classifies them and works out the rotated source point
// ============================================================================
module irck_front #(
  parameter int unsigned MAX_DIM        = irck_pkg::MAX_DIM_DEF,
  parameter int unsigned TRIG_FRAC_BITS = irck_pkg::TRIG_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irck_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  irck_pkg::in_req_t in_req_i,
  input  logic              q_full_i,
  output logic              push_o,
  output irck_pkg::cmd_t    cmd_o
);
  import irck_pkg::*;

  localparam int unsigned TAB_W  = TRIG_FRAC_BITS + 1;
  localparam int unsigned SIN_W  = TRIG_FRAC_BITS + 2;
  localparam int unsigned OFF_W  = 9;
  localparam int unsigned PROD_W = SIN_W + OFF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned CRD_W  = 11;

  typedef struct packed {
    logic [1:0]                action;
    logic [POS_W-1:0]          column;
    logic [POS_W-1:0]          row;
    logic [COLOR_W-1:0]        color;
    logic                      in_image;
    logic signed [PROD_W-1:0]  p_sy;
    logic signed [PROD_W-1:0]  p_cx;
    logic signed [PROD_W-1:0]  p_cy;
    logic signed [PROD_W-1:0]  p_sx;
  } s1_t;

  // quarter-wave sine table
  logic [TAB_W-1:0] sine_tab [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_tab
    localparam logic [TAB_W-1:0] SineVal = TAB_W'(irck_sine_q(k, TRIG_FRAC_BITS));
    assign sine_tab[k] = SineVal;
  end

  // {negate, table index} for an angle in 0..359
  function automatic logic [7:0] fold_angle(input logic [8:0] a);
    logic [8:0] idx;
    logic       neg;
    if (a <= DEG_90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= DEG_180) begin
      idx = DEG_180 - a;
      neg = 1'b0;
    end else if (a <= DEG_270) begin
      idx = a - DEG_180;
      neg = 1'b1;
    end else begin
      idx = DEG_360 - a;
      neg = 1'b1;
    end
    return {neg, idx[6:0]};
  endfunction

  function automatic logic signed [CRD_W-1:0] trunc0(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    q   = mag >> TRIG_FRAC_BITS;
    return v[SUM_W-1] ? -$signed(CRD_W'(q)) : $signed(CRD_W'(q));
  endfunction

  // trig values follow the angle register
  logic [8:0]              ang_a;
  logic [8:0]              ang_b;
  logic [8:0]              ang_b_raw;
  logic [7:0]              fold_s;
  logic [7:0]              fold_c;
  logic signed [SIN_W-1:0] sin_d, cos_d;
  logic signed [SIN_W-1:0] sin_q, cos_q;

  always_comb begin
    ang_a     = (cfg_i.angle >= DEG_360) ? cfg_i.angle - DEG_360 : cfg_i.angle;
    ang_b_raw = ang_a + DEG_90;
    ang_b     = (ang_b_raw >= DEG_360) ? ang_b_raw - DEG_360 : ang_b_raw;
    fold_s    = fold_angle(ang_a);
    fold_c    = fold_angle(ang_b);
    sin_d     = $signed({1'b0, sine_tab[fold_s[6:0]]});
    cos_d     = $signed({1'b0, sine_tab[fold_c[6:0]]});
    if (fold_s[7]) begin
      sin_d = -sin_d;
    end
    if (fold_c[7]) begin
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  // clamped image size and its halves
  logic [7:0] img_w, img_h;
  logic [7:0] half_w, half_h;

  always_comb begin
    img_w = cfg_i.width;
    img_h = cfg_i.height;
    if (cfg_i.width == '0) begin
      img_w = 8'd1;
    end else if (32'(cfg_i.width) > MAX_DIM) begin
      img_w = 8'(MAX_DIM);
    end
    if (cfg_i.height == '0) begin
      img_h = 8'd1;
    end else if (32'(cfg_i.height) > MAX_DIM) begin
      img_h = 8'(MAX_DIM);
    end
    half_w = img_w >> 1;
    half_h = img_h >> 1;
  end

  // pipeline control
  logic    s0_valid_q, s0_valid_d;
  in_req_t s0_q;
  logic    s1_valid_q, s1_valid_d;
  s1_t     s1_q, s1_d;
  logic    s0_adv, s1_adv;
  logic    in_accept;
  logic    known_action;

  assign push_o     = s1_valid_q && !q_full_i;
  assign s1_adv     = !s1_valid_q || push_o;
  assign s0_adv     = !s0_valid_q || s1_adv;
  assign in_stall_o = !s0_adv;
  assign in_accept  = in_valid_i && s0_adv;

  assign known_action = (in_req_i.action == ACT_LOAD) || (in_req_i.action == ACT_ROTATE) ||
                        (in_req_i.action == ACT_READ);

  always_comb begin
    s0_valid_d = s0_valid_q;
    s1_valid_d = s1_valid_q;
    if (s0_adv) begin
      s0_valid_d = in_accept && known_action;
    end
    if (s1_adv) begin
      s1_valid_d = s0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage 0: offsets and products
  logic signed [OFF_W-1:0] off_i, off_j;

  always_comb begin
    off_i          = $signed({2'b00, s0_q.column}) - $signed({1'b0, half_w});
    off_j          = $signed({2'b00, s0_q.row}) - $signed({1'b0, half_h});
    s1_d.action    = s0_q.action;
    s1_d.column    = s0_q.column;
    s1_d.row       = s0_q.row;
    s1_d.color     = s0_q.pixel_color;
    s1_d.in_image  = ({1'b0, s0_q.column} < img_w) && ({1'b0, s0_q.row} < img_h);
    s1_d.p_sy      = sin_q * off_j;
    s1_d.p_cx      = cos_q * off_i;
    s1_d.p_cy      = cos_q * off_j;
    s1_d.p_sx      = sin_q * off_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_q <= in_req_i;
    end
    if (s1_adv) begin
      s1_q <= s1_d;
    end
  end

  // stage 1: truncate, re-center, range check, build the command
  logic signed [SUM_W-1:0] sum_i, sum_j;
  logic signed [CRD_W-1:0] src_i, src_j;
  logic                    src_ok;

  always_comb begin
    sum_i  = SUM_W'(s1_q.p_sy) + SUM_W'(s1_q.p_cx);
    sum_j  = SUM_W'(s1_q.p_cy) - SUM_W'(s1_q.p_sx);
    src_i  = trunc0(sum_i) + $signed(CRD_W'(half_w));
    src_j  = trunc0(sum_j) + $signed(CRD_W'(half_h));
    src_ok = !src_i[CRD_W-1] && (src_i < $signed(CRD_W'(img_w))) &&
             !src_j[CRD_W-1] && (src_j < $signed(CRD_W'(img_h)));

    cmd_o.column  = s1_q.column;
    cmd_o.row     = s1_q.row;
    cmd_o.src_col = src_i[SRC_W-1:0];
    cmd_o.src_row = src_j[SRC_W-1:0];
    cmd_o.color   = s1_q.color;
    case (s1_q.action)
      ACT_LOAD:   cmd_o.kind = CMD_LOAD;
      ACT_ROTATE: cmd_o.kind = (s1_q.in_image && src_ok) ? CMD_COPY : CMD_READ;
      default:    cmd_o.kind = CMD_READ;
    endcase
  end

endmodule

// ----- rtl/irck_queue.sv -----
// ============================================================================
// irck_queue
// short command fifo between the front and the back
// ============================================================================
module irck_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irck_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output irck_pkg::cmd_t head_o,
  output logic           empty_o
);
  import irck_pkg::*;

  localparam int unsigned QI_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem [QUEUE_DEPTH];
  logic [QI_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QI_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == QC_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/irck_back.sv -----
// ============================================================================
// irck_back
// carries out commands on the two pixel stores and drives the result register
// ============================================================================
module irck_back #(
  parameter int unsigned MAX_DIM = irck_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irck_pkg::cfg_t     cfg_i,
  input  irck_pkg::cmd_t     head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output irck_pkg::out_res_t out_res_o
);
  import irck_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  // coordinate wrap onto the store, a few compare-subtract steps
  function automatic logic [SRC_W-1:0] wrap_dim(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (32'(r) >= MAX_DIM) begin
        r = r - SRC_W'(MAX_DIM);
      end
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SRC_W-1:0] c,
                                            input logic [SRC_W-1:0] r);
    return AW'(wrap_dim(r)) * AW'(MAX_DIM) + AW'(wrap_dim(c));
  endfunction

  bk_state_e state_q, state_d;
  cmd_t      cmd_q, cmd_d;

  logic               src_we, src_re, rot_we, rot_re;
  logic [AW-1:0]      head_dst, head_src, cur_dst;
  logic [AW-1:0]      rot_waddr;
  logic [COLOR_W-1:0] rot_wdata;
  logic [COLOR_W-1:0] src_rdata, rot_rdata;
  logic               out_free, capture;
  logic               out_valid_q, out_valid_d;
  out_res_t           out_q, out_d;

  assign head_dst = addr_of({1'b0, head_i.column}, {1'b0, head_i.row});
  assign head_src = addr_of(head_i.src_col, head_i.src_row);
  assign cur_dst  = addr_of({1'b0, cmd_q.column}, {1'b0, cmd_q.row});
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    pop_o   = 1'b0;
    src_we  = 1'b0;
    src_re  = 1'b0;
    rot_we  = 1'b0;
    rot_re  = 1'b0;
    capture = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          case (head_i.kind)
            CMD_LOAD: begin
              src_we = 1'b1;
              rot_we = 1'b1;
            end
            CMD_READ: begin
              rot_re  = 1'b1;
              state_d = BK_WAIT;
            end
            CMD_COPY: begin
              src_re  = 1'b1;
              state_d = BK_WAIT;
            end
            default: ;
          endcase
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          capture = 1'b1;
          rot_we  = (cmd_q.kind == CMD_COPY);
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign rot_waddr = (state_q == BK_IDLE) ? head_dst : cur_dst;
  assign rot_wdata = (state_q == BK_IDLE) ? head_i.color : src_rdata;

  irck_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(head_dst),
    .wdata_i(head_i.color),
    .re_i   (src_re),
    .raddr_i(head_src),
    .rdata_o(src_rdata)
  );

  irck_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_rot_ram (
    .clk_i  (clk_i),
    .we_i   (rot_we),
    .waddr_i(rot_waddr),
    .wdata_i(rot_wdata),
    .re_i   (rot_re),
    .raddr_i(head_dst),
    .rdata_o(rot_rdata)
  );

  // result register
  always_comb begin
    out_valid_d               = out_valid_q && out_stall_i;
    out_d                     = out_q;
    out_d.out_column          = cmd_q.column;
    out_d.out_row             = cmd_q.row;
    out_d.source_in_range     = (cmd_q.kind == CMD_COPY);
    out_d.out_color           = (cmd_q.kind == CMD_COPY) ? src_rdata : rot_rdata;
    out_d.out_alpha           = (cfg_i.key_enable && (out_d.out_color == cfg_i.key_color)) ?
                                ALPHA_CLEAR : ALPHA_OPAQUE;
    if (capture) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (capture) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ----- rtl/image_rotate_color_key_top.sv -----
// ============================================================================
// image_rotate_color_key_top
// nearest-neighbor image rotation with color keying over two pixel stores
// ============================================================================
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  ------------------------------
//   in        in         in_valid_i / in_stall_o  in_req_i  (action, pixel, color)
//   out       out        out_valid_o/out_stall_i  out_res_o (pixel, color, alpha)
//   cfg       in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// in the front a request has its offsets and products formed, then is truncated and
// range checked, before it enters a four-deep command queue.
// the back does a load in its idle state; a rotate or read goes through idle and wait (store
// read, then write-back of a copy and result capture), and no new command is taken meanwhile.
// reset clears the pipeline, queue and result valid and puts the registers
// at 128, 128, 0, 0, 0; the stores are not cleared.
// a stalled result holds the back in its wait state; the front keeps taking
// requests until the queue fills.
//
module image_rotate_color_key_top #(
  parameter int unsigned MAX_DIM        = irck_pkg::MAX_DIM_DEF,
  parameter int unsigned TRIG_FRAC_BITS = irck_pkg::TRIG_FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [irck_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [irck_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  irck_pkg::in_req_t                   in_req_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output irck_pkg::out_res_t                  out_res_o
);
  import irck_pkg::*;

  // register file
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  cfg_d.width      = cfg_data_i[7:0];
        REG_HEIGHT: cfg_d.height     = cfg_data_i[7:0];
        REG_ANGLE:  cfg_d.angle      = cfg_data_i[8:0];
        REG_KEY:    cfg_d.key_color  = cfg_data_i[COLOR_W-1:0];
        REG_KEY_EN: cfg_d.key_enable = cfg_data_i[0];
        default:    ; // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width      <= WIDTH_RST;
      cfg_q.height     <= HEIGHT_RST;
      cfg_q.angle      <= ANGLE_RST;
      cfg_q.key_color  <= KEY_RST;
      cfg_q.key_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  cmd_t head;
  logic q_empty;
  logic pop;

  // front: classify and compute the source point
  irck_front #(
    .MAX_DIM       (MAX_DIM),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // decoupling queue
  irck_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty)
  );

  // back: store accesses, keying and result register
  irck_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule

// ----- tb/image_rotate_color_key_checker.sv -----
// ============================================================================
// image_rotate_color_key_checker
// watches the request, result and register ports of the rotate / color key
// block, keeps its own copy of both pixel stores and the registers, predicts
// every result and compares it field by field in arrival order
// ============================================================================
module image_rotate_color_key_checker
  import irck_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_req_t               in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_res_t              out_res_i,
  input  logic                  end_i,
  output int                    errors_o
);

  localparam int unsigned FRAC      = TRIG_FRAC_DEF;
  localparam int unsigned DIM       = MAX_DIM_DEF;
  localparam int unsigned PRINT_CAP = 40;

  longint             trig_q [0:90];
  logic [COLOR_W-1:0] src_img [0:DIM*DIM-1];
  logic [COLOR_W-1:0] rot_img [0:DIM*DIM-1];
  cfg_t               cfg;
  out_res_t           pending_pixels [$];
  int                 err_count = 0;
  bit                 end_seen = 1'b0;

  assign errors_o = err_count;

  // sin(k degrees) in q31, taylor series on unsigned fixed point
  function automatic longint unsigned taylor_sine_q31(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned den;
    x    = (64'(k) * PI_Q31 + 64'd90) / 64'd180;
    x2   = (x * x) >> 31;
    term = x;
    pos  = x;
    neg  = 0;
    for (int unsigned n = 1; n < 20 && term != 0; n++) begin
      den  = 64'(2 * n) * 64'(2 * n + 1);
      term = ((term * x2) >> 31) / den;
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // quadrant folding onto the 0..90 table
  function automatic longint sine_of(input int unsigned a);
    a = a % 360;
    if (a <= 90) return trig_q[a];
    if (a <= 180) return trig_q[180 - a];
    if (a <= 270) return -trig_q[a - 180];
    return -trig_q[360 - a];
  endfunction

  function automatic longint trunc_frac(input longint v);
    if (v < 0) return -((-v) >>> FRAC);
    return v >>> FRAC;
  endfunction

  function automatic longint clamp_dim(input logic [7:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < PRINT_CAP) $display("%0t pixel check: %s", $time, what);
    err_count++;
  endtask

  // update the stores for one request and queue its result, if any
  task automatic apply_request(input in_req_t r);
    out_res_t           res;
    longint             w;
    longint             h;
    longint             hw;
    longint             hh;
    longint             oi;
    longint             oj;
    longint             s;
    longint             c;
    longint             ti;
    longint             tj;
    int unsigned        idx;
    logic [COLOR_W-1:0] color;
    idx = r.row * DIM + r.column;
    res.source_in_range = 1'b0;
    if (r.action == ACT_LOAD) begin
      src_img[idx] = r.pixel_color;
      rot_img[idx] = r.pixel_color;
    end else if (r.action == ACT_ROTATE || r.action == ACT_READ) begin
      if (r.action == ACT_ROTATE) begin
        w = clamp_dim(cfg.width);
        h = clamp_dim(cfg.height);
        if (r.column < w && r.row < h) begin
          hw = w / 2;
          hh = h / 2;
          oi = longint'(r.column) - hw;
          oj = longint'(r.row) - hh;
          s  = sine_of(cfg.angle % 360);
          c  = sine_of(cfg.angle % 360 + 90);
          ti = trunc_frac(s * oj + c * oi) + hw;
          tj = trunc_frac(c * oj - s * oi) + hh;
          if (ti >= 0 && ti < w && tj >= 0 && tj < h) begin
            rot_img[idx] = src_img[tj * DIM + ti];
            res.source_in_range = 1'b1;
          end
        end
      end
      color          = rot_img[idx];
      res.out_column = r.column;
      res.out_row    = r.row;
      res.out_color  = color;
      res.out_alpha  = (cfg.key_enable && color == cfg.key_color) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      pending_pixels.insert(pending_pixels.size(), res);
    end
  endtask

  task automatic check_result(input out_res_t got);
    out_res_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("result arrived with no request pending");
      return;
    end
    want = pending_pixels.pop_front();
    if (got.out_column !== want.out_column)
      report_mismatch($sformatf("column got %0d want %0d", got.out_column, want.out_column));
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("row got %0d want %0d", got.out_row, want.out_row));
    if (got.out_color !== want.out_color)
      report_mismatch($sformatf("color at (%0d,%0d) got %06h want %06h",
                                want.out_column, want.out_row, got.out_color, want.out_color));
    if (got.out_alpha !== want.out_alpha)
      report_mismatch($sformatf("alpha at (%0d,%0d) got %0d want %0d",
                                want.out_column, want.out_row, got.out_alpha, want.out_alpha));
    if (got.source_in_range !== want.source_in_range)
      report_mismatch($sformatf("in range flag at (%0d,%0d) got %b want %b", want.out_column,
                                want.out_row, got.source_in_range, want.source_in_range));
  endtask

  initial begin
    longint unsigned v;
    for (int k = 0; k <= 90; k++) begin
      v = taylor_sine_q31(k);
      trig_q[k] = longint'((v + (64'd1 << (30 - FRAC))) >> (31 - FRAC));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.width      = WIDTH_RST;
      cfg.height     = HEIGHT_RST;
      cfg.angle      = ANGLE_RST;
      cfg.key_color  = KEY_RST;
      cfg.key_enable = 1'b0;
      pending_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_res_i);
      if (in_valid_i && !in_stall_i) apply_request(in_req_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  cfg.width      = cfg_data_i[7:0];
          REG_HEIGHT: cfg.height     = cfg_data_i[7:0];
          REG_ANGLE:  cfg.angle      = cfg_data_i[8:0];
          REG_KEY:    cfg.key_color  = cfg_data_i[COLOR_W-1:0];
          REG_KEY_EN: cfg.key_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (pending_pixels.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
      end
    end
  end

endmodule

// ----- tb/image_rotate_color_key_top_test.sv -----
// ============================================================================
// image_rotate_color_key_top_test
// drives pixel loads, rotates and reads into the rotate / color key block
// under several image sizes, angles and key settings, with random gaps on the
// request side and random stalls on the result side; a checker beside the
// block predicts and compares every result, this module gives the verdict
// ============================================================================
module image_rotate_color_key_top_test;
  import irck_pkg::*;

  localparam int unsigned DIM             = MAX_DIM_DEF;
  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  // images up to this many pixels get fully loaded, so any angle is safe
  localparam int          FULL_REGION_MAX = 512;
  // extra idle clocks after the last result, to let the pipeline drain
  localparam int unsigned DRAIN_CYCLES    = 20;
  // requests per phase, unknown actions apart; preloads of unloaded entries add to the traffic
  localparam int unsigned PHASE_ITEMS     = 60;
  localparam int unsigned NUM_PHASES      = 10;
  localparam longint      RUN_LIMIT       = 20_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_req;
  logic                  out_valid;
  logic                  out_stall;
  out_res_t              out_res;
  logic                  check_end;
  int                    errors;

  // which store entries hold a loaded color
  bit                    loaded [0:DIM*DIM-1];

  // current effective geometry as the block sees it
  int                    eff_w = DIM;
  int                    eff_h = DIM;
  int                    eff_angle = 0;
  bit                    region_ready = 1'b0;
  logic [COLOR_W-1:0]    key_now = '0;

  int unsigned           results_owed = 0;
  int unsigned           results_seen = 0;
  int unsigned           gap_free_left = 0;

  image_rotate_color_key_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  image_rotate_color_key_checker u_pixel_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_res_i   (out_res),
    .end_i       (check_end),
    .errors_o    (errors)
  );

  // 20 unit clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // results taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) results_seen++;
  end

  // receiver: free runs, mostly short, sometimes long, then stall bursts
  initial begin
    int unsigned free_len;
    int unsigned stall_len;
    int unsigned roll;
    out_stall = 1'b0;
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 10) free_len = $urandom_range(40, 100);
      else free_len = $urandom_range(0, 6);
      roll = $urandom_range(0, 99);
      if (roll < 85) stall_len = $urandom_range(1, 3);
      else if (roll < 97) stall_len = $urandom_range(4, 12);
      else stall_len = $urandom_range(20, 40);
      repeat (free_len) @(negedge clk_i) out_stall <= 1'b0;
      repeat (stall_len) @(negedge clk_i) out_stall <= 1'b1;
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("image_rotate_color_key_top_test: errors");
    $finish;
  end

  function automatic int clamp_dim(input int raw);
    raw = raw & 255;
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return raw;
  endfunction

  // idle cycles ahead of the next request, with occasional runs of none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (gap_free_left > 0) begin
      gap_free_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      gap_free_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // present one request and hold it until the block takes it
  task automatic send_req(input in_req_t r);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (r.action == ACT_LOAD) loaded[r.row * DIM + r.column] = 1'b1;
    else if (r.action == ACT_ROTATE || r.action == ACT_READ) results_owed++;
  endtask

  task automatic send_load(input int col, input int row, input logic [COLOR_W-1:0] color);
    in_req_t r;
    r.action      = ACT_LOAD;
    r.column      = 7'(col);
    r.row         = 7'(row);
    r.pixel_color = color;
    send_req(r);
  endtask

  // source pixel of a rotate at a quarter turn, where sine and cosine are exact
  task automatic quarter_source(input int col, input int row, output int ti, output int tj);
    int hw;
    int hh;
    int oi;
    int oj;
    hw = eff_w / 2;
    hh = eff_h / 2;
    oi = col - hw;
    oj = row - hh;
    case (eff_angle / 90)
      0: begin ti = oi + hw;  tj = oj + hh;  end
      1: begin ti = oj + hw;  tj = -oi + hh; end
      2: begin ti = -oi + hw; tj = -oj + hh; end
      default: begin ti = -oj + hw; tj = oi + hh; end
    endcase
  endtask

  // send a request, first loading whatever store entry it would read
  task automatic issue(input logic [1:0] act, input int col, input int row,
                       input logic [COLOR_W-1:0] color);
    in_req_t r;
    int      ti;
    int      tj;
    if (act == ACT_ROTATE || act == ACT_READ) begin
      if (!loaded[row * DIM + col]) send_load(col, row, COLOR_W'($urandom));
      // a large image only ever runs at quarter turns, so its source is known
      if (act == ACT_ROTATE && !region_ready && col < eff_w && row < eff_h) begin
        quarter_source(col, row, ti, tj);
        if (ti >= 0 && ti < eff_w && tj >= 0 && tj < eff_h && !loaded[tj * DIM + ti])
          send_load(ti, tj, COLOR_W'($urandom));
      end
    end
    r.action      = act;
    r.column      = 7'(col);
    r.row         = 7'(row);
    r.pixel_color = color;
    send_req(r);
  endtask

  // stop sending and let every result and the pipeline drain
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (results_seen != results_owed) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // rewrite every register with the block idle; unused upper data bits are junk
  task automatic set_config(input int raw_w, input int raw_h, input int raw_angle,
                            input logic [COLOR_W-1:0] key, input bit key_on);
    wait_quiet();
    cfg_write(REG_WIDTH, {16'($urandom), 8'(raw_w)});
    cfg_write(REG_HEIGHT, {16'($urandom), 8'(raw_h)});
    cfg_write(REG_ANGLE, {15'($urandom), 9'(raw_angle)});
    cfg_write(REG_KEY, key);
    cfg_write(REG_KEY_EN, {23'($urandom), key_on});
    @(negedge clk_i);
    cfg_we <= 1'b0;
    eff_w        = clamp_dim(raw_w);
    eff_h        = clamp_dim(raw_h);
    eff_angle    = (raw_angle & 511) % 360;
    key_now      = key;
    region_ready = (eff_w * eff_h <= FULL_REGION_MAX);
    // small image: load every pixel so any rotation finds a loaded source
    if (region_ready) begin
      for (int r = 0; r < eff_h; r++) begin
        for (int c = 0; c < eff_w; c++) begin
          if (!loaded[r * DIM + c]) send_load(c, r, COLOR_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    int unsigned        shape;
    int                 raw_w;
    int                 raw_h;
    int                 raw_angle;
    int unsigned        q;
    int unsigned        done;
    int unsigned        roll;
    logic [1:0]         act;
    int                 col;
    int                 row;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] key;

    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    check_end = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part, reset registers: 128 x 128, angle 0, no keying
    issue(ACT_LOAD, 0, 0, 24'h000000);
    issue(ACT_LOAD, 127, 127, 24'hFFFFFF);
    issue(ACT_LOAD, 127, 0, 24'h0000FF);
    issue(ACT_LOAD, 0, 127, 24'hFF0000);
    // zero angle copies each pixel onto itself
    issue(ACT_ROTATE, 0, 0, 24'hFFFFFF);
    issue(ACT_ROTATE, 127, 127, 24'h000000);
    issue(ACT_READ, 127, 0, 24'h0);
    issue(ACT_READ, 0, 127, 24'h0);
    // unknown action gives no result
    issue(ACT_UNUSED, 127, 127, 24'hFFFFFF);

    // half turn: the corner pixel maps outside the image
    set_config(128, 128, 180, 24'hFFFFFF, 1'b1);
    issue(ACT_ROTATE, 0, 0, 24'h0);
    issue(ACT_ROTATE, 127, 127, 24'h0);
    issue(ACT_LOAD, 64, 64, 24'hFFFFFF);
    issue(ACT_READ, 64, 64, 24'h0);
    issue(ACT_ROTATE, 64, 64, 24'h0);

    // sizes of zero saturate to one, angle 511 wraps to 151
    set_config(0, 0, 511, 24'h0000FF, 1'b1);
    issue(ACT_ROTATE, 0, 0, 24'h0);
    issue(ACT_ROTATE, 100, 5, 24'h0);
    issue(ACT_READ, 127, 0, 24'h0);

    // oversize saturates to 128, angle 450 wraps to a quarter turn
    set_config(255, 255, 450, 24'h000000, 1'b0);
    issue(ACT_ROTATE, 127, 0, 24'h0);
    issue(ACT_ROTATE, 0, 127, 24'h0);
    issue(ACT_ROTATE, 1, 1, 24'h0);

    // ---- random phases over shapes, angles and keys
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      shape = (ph < 3) ? ph : $urandom_range(0, 2);
      case (shape)
        0: begin
          raw_w = $urandom_range(64, 255);
          raw_h = $urandom_range(64, 255);
        end
        1: begin
          raw_w = $urandom_range(0, 32);
          raw_h = $urandom_range(0, 16);
        end
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            raw_w = $urandom_range(128, 255);
            raw_h = $urandom_range(0, 3);
          end else begin
            raw_w = $urandom_range(0, 3);
            raw_h = $urandom_range(128, 255);
          end
        end
      endcase
      // large images stay at quarter turns, small ones take any angle
      if (clamp_dim(raw_w) * clamp_dim(raw_h) > FULL_REGION_MAX) begin
        q         = $urandom_range(0, 3);
        raw_angle = q * 90 + ((q < 2 && $urandom_range(0, 1) == 1) ? 360 : 0);
      end else begin
        raw_angle = (ph == 1) ? 359 : $urandom_range(0, 511);
      end
      key = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : COLOR_W'($urandom);
      set_config(raw_w, raw_h, raw_angle, key, (ph % 3 != 0));

      done = 0;
      while (done < PHASE_ITEMS) begin
        // one mid-phase hold-off until every result is back
        if (ph == 4 && done == PHASE_ITEMS / 2) wait_quiet();
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          issue(ACT_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                COLOR_W'($urandom));
        end else begin
          if (roll < 35) act = ACT_LOAD;
          else if (roll < 75) act = ACT_ROTATE;
          else act = ACT_READ;
          // mostly inside the image, sometimes anywhere in the store
          if ($urandom_range(0, 4) != 0) begin
            col = $urandom_range(0, eff_w - 1);
            row = $urandom_range(0, eff_h - 1);
          end else begin
            col = $urandom_range(0, 127);
            row = $urandom_range(0, 127);
          end
          color = ($urandom_range(0, 6) == 0) ? key_now : COLOR_W'($urandom);
          issue(act, col, row, color);
          done++;
        end
      end
    end

    // ---- drain, flag leftovers, verdict
    wait_quiet();
    @(negedge clk_i);
    check_end <= 1'b1;
    @(negedge clk_i);
    if (errors == 0) begin
      $display("image_rotate_color_key_top_test: clean");
    end else begin
      $display("image_rotate_color_key_top_test: errors");
    end
    $finish;
  end

endmodule
